// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("timer queue check failed");

// Antecedent in one cycle, consequent in the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("timer queue sequence check failed");

`endif

// ===== sv/dotq_pkg.sv =====
// ----------------------------------------------------------------------------
// dotq_pkg
// Types and codes shared by the timer queue controller and datapath.
// ----------------------------------------------------------------------------
package dotq_pkg;

	localparam int TIME_W   = 32;
	localparam int ID_W     = 16;
	localparam int PER_W    = 24;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FIRED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [TIME_W-1:0] due;
		logic [ID_W-1:0]   id;
		logic [PER_W-1:0]  per;
		logic              rep;
		logic              dly;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_REINS
	} state_t;

	typedef struct packed {
		logic                load;
		logic                ins_new;
		logic                ins_rep;
		logic                pop;
		logic                rm_step;
		logic                res_wr;
		logic [STATUS_W-1:0] res_status;
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              full;
		logic              head_due;
		logic              rep_needed;
		logic              rm_hit;
	} stat_t;

endpackage

// ===== sv/dotq_dp.sv =====
// ----------------------------------------------------------------------------
// dotq_dp
// Sorted shift-register queue with per-slot compare, item latch, reinsert
// holding register and result registers.
// ----------------------------------------------------------------------------
module dotq_dp #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dotq_pkg::cmd_t                     cmd,
	output dotq_pkg::stat_t                    stat,
	input  logic [dotq_pkg::FUNC_W-1:0]        func,
	input  logic [dotq_pkg::ID_W-1:0]          msg_id,
	input  logic [dotq_pkg::TIME_W-1:0]        due_time,
	input  logic                               repeat_req,
	input  logic [dotq_pkg::PER_W-1:0]         period_ms,
	input  logic                               delayed,
	input  logic [dotq_pkg::TIME_W-1:0]        now_time,
	output logic                               done,
	output logic [dotq_pkg::STATUS_W-1:0]      status,
	output logic [dotq_pkg::ID_W-1:0]          fired_id,
	output logic [dotq_pkg::ID_W-1:0]          end_id,
	output logic [dotq_pkg::OCC_W-1:0]         occupancy
);
	import dotq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	entry_t                   entry_q [QUEUE_DEPTH];
	entry_t                   entry_d [QUEUE_DEPTH];
	logic [CW-1:0]            count_q;
	logic [FUNC_W-1:0]        op_func_q;
	entry_t                   op_new_q;
	logic [TIME_W-1:0]        op_now_q;
	entry_t                   rein_q;
	logic                     done_q;
	logic [STATUS_W-1:0]      status_q;
	logic [ID_W-1:0]          fired_id_q;
	logic [ID_W-1:0]          end_id_q;

	entry_t                   ins_ent;
	entry_t                   head;
	entry_t                   src;
	logic                     ins_any;
	logic                     shrink;
	logic [QUEUE_DEPTH-1:0]   valid;
	logic [QUEUE_DEPTH-1:0]   le;
	logic [QUEUE_DEPTH-1:0]   match;
	logic [QUEUE_DEPTH-1:0]   shift;

	assign ins_any = cmd.ins_new | cmd.ins_rep;
	assign ins_ent = cmd.ins_rep ? rein_q : op_new_q;
	assign head    = entry_q[0];
	assign src     = cmd.pop ? head : rein_q;

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			valid[i] = CW'(i) < count_q;
			le[i]    = valid[i] && (entry_q[i].due <= ins_ent.due);
			match[i] = valid[i] && (entry_q[i].id == op_new_q.id);
		end
	end

	// slots at and above the first match move down by one
	assign shift = match | (~match + QUEUE_DEPTH'(1));

	assign stat.func       = op_func_q;
	assign stat.full       = count_q == CW'(QUEUE_DEPTH);
	assign stat.head_due   = (count_q != '0) && (head.due <= op_now_q);
	assign stat.rep_needed = head.rep && (head.per != '0);
	assign stat.rm_hit     = |match;

	assign shrink = cmd.pop | (cmd.rm_step & stat.rm_hit);

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
		entry_t below;
		entry_t above;
		logic   le_below;

		if (i == 0) begin : g_head
			assign below    = ins_ent;
			assign le_below = 1'b1;
		end else begin : g_body
			assign below    = entry_q[i-1];
			assign le_below = le[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign above = entry_q[i];
		end else begin : g_inner
			assign above = entry_q[i+1];
		end

		assign entry_d[i] = ins_any ? (le[i] ? entry_q[i] : (le_below ? ins_ent : below))
			: (cmd.pop || (cmd.rm_step && shift[i])) ? above : entry_q[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.res_wr;
			if (ins_any) begin
				count_q <= count_q + CW'(1);
			end else if (shrink) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
		if (cmd.load) begin
			op_func_q    <= func;
			op_new_q.due <= due_time;
			op_new_q.id  <= msg_id;
			op_new_q.per <= period_ms;
			op_new_q.rep <= repeat_req;
			op_new_q.dly <= delayed;
			op_now_q     <= now_time;
		end
		if (cmd.pop) begin
			rein_q.due <= op_now_q + TIME_W'(head.per);
			rein_q.id  <= head.id;
			rein_q.per <= head.per;
			rein_q.rep <= head.rep;
			rein_q.dly <= head.dly;
		end
		if (cmd.res_wr) begin
			status_q <= cmd.res_status;
			if (cmd.res_status == STATUS_FIRED) begin
				fired_id_q <= src.id;
				end_id_q   <= src.dly ? src.id : '0;
			end else begin
				fired_id_q <= '0;
				end_id_q   <= '0;
			end
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign fired_id  = fired_id_q;
	assign end_id    = end_id_q;
	assign occupancy = OCC_W'(count_q);

endmodule

// ===== sv/dotq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dotq_ctrl
// Sequencer for insert, remove, tick and reinsert steps of the timer queue.
// ----------------------------------------------------------------------------
module dotq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  dotq_pkg::stat_t stat,
	output dotq_pkg::cmd_t  cmd,
	output logic            busy
);
	import dotq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = state_q != ST_IDLE;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (stat.func)
					FUNC_INSERT: begin
						cmd.res_wr = 1'b1;
						if (stat.full) begin
							cmd.res_status = STATUS_FULL;
						end else begin
							cmd.ins_new    = 1'b1;
							cmd.res_status = STATUS_OK;
						end
						state_d = ST_IDLE;
					end
					FUNC_REMOVE: begin
						// drop one match per cycle until none is left
						cmd.rm_step = 1'b1;
						if (!stat.rm_hit) begin
							cmd.res_wr     = 1'b1;
							cmd.res_status = STATUS_OK;
							state_d        = ST_IDLE;
						end
					end
					FUNC_TICK: begin
						if (stat.head_due) begin
							cmd.pop = 1'b1;
							if (stat.rep_needed) begin
								state_d = ST_REINS;
							end else begin
								cmd.res_wr     = 1'b1;
								cmd.res_status = STATUS_FIRED;
								state_d        = ST_IDLE;
							end
						end else begin
							cmd.res_wr     = 1'b1;
							cmd.res_status = STATUS_OK;
							state_d        = ST_IDLE;
						end
					end
					default: begin
						cmd.res_wr     = 1'b1;
						cmd.res_status = STATUS_OK;
						state_d        = ST_IDLE;
					end
				endcase
			end
			ST_REINS: begin
				cmd.ins_rep    = 1'b1;
				cmd.res_wr     = 1'b1;
				cmd.res_status = STATUS_FIRED;
				state_d        = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/deadline_ordered_timer_queue_top.sv =====
// ----------------------------------------------------------------------------
// deadline_ordered_timer_queue_top
// Timer queue of messages kept sorted by due time, with periodic reschedule.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive func and its operand fields and raise start; the
//   item is taken on a rising edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle with status,
//   fired_id, end_id and occupancy; the receiver must take it then.
// Sequence from accept to done:
//   insert, unused code, tick with nothing due or without recurrence: execute
//   tick that fires a recurring message: pop, then reinsert
//   remove: entries holding the id are dropped one per cycle, then done
// A new item is taken in the cycle that done is high. The remove loop over
//   the slot array and the pop-then-insert of a recurring message keep the
//   sequencer busy for longer.
// Reset: clears the entry count, done and the sequencer; slot contents are
//   unknown until written and are never read beyond the count.
// The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module deadline_ordered_timer_queue_top #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dotq_pkg::FUNC_W-1:0]   func,
	input  logic [dotq_pkg::ID_W-1:0]     msg_id,
	input  logic [dotq_pkg::TIME_W-1:0]   due_time,
	input  logic                          repeat_req,
	input  logic [dotq_pkg::PER_W-1:0]    period_ms,
	input  logic                          delayed,
	input  logic [dotq_pkg::TIME_W-1:0]   now_time,
	output logic                          busy,
	output logic                          done,
	output logic [dotq_pkg::STATUS_W-1:0] status,
	output logic [dotq_pkg::ID_W-1:0]     fired_id,
	output logic [dotq_pkg::ID_W-1:0]     end_id,
	output logic [dotq_pkg::OCC_W-1:0]    occupancy
);
	import dotq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	dotq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	dotq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.func       (func),
		.msg_id     (msg_id),
		.due_time   (due_time),
		.repeat_req (repeat_req),
		.period_ms  (period_ms),
		.delayed    (delayed),
		.now_time   (now_time),
		.done       (done),
		.status     (status),
		.fired_id   (fired_id),
		.end_id     (end_id),
		.occupancy  (occupancy)
	);

endmodule

// ===== sv/dotq_checker.sv =====
// ----------------------------------------------------------------------------
// dotq_checker
// Port-level checks of the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dotq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [dotq_pkg::STATUS_W-1:0] status,
	input logic [dotq_pkg::ID_W-1:0]     fired_id,
	input logic [dotq_pkg::ID_W-1:0]     end_id
);
	import dotq_pkg::*;

	`ASSERT_CLK(a_done_idle, clk, arst_n, done |-> !busy)
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy && !done)
	`ASSERT_CLK(a_status_code, clk, arst_n, done |-> (status <= STATUS_FULL))
	`ASSERT_CLK(a_end_id, clk, arst_n, done |-> (end_id == '0 || end_id == fired_id))
	`ASSERT_CLK(a_idle_ids, clk, arst_n, (done && status != STATUS_FIRED) |-> !(|fired_id || |end_id))

endmodule

bind deadline_ordered_timer_queue_top dotq_checker u_dotq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.status   (status),
	.fired_id (fired_id),
	.end_id   (end_id)
);

// ===== tb/tb_deadline_ordered_timer_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deadline_ordered_timer_queue_top
// Self-checking bench for the sorted timer queue. A clocked driver feeds
// insert, remove, tick and unused-code items from a backlog, with random
// gaps, a gap-free stretch and pauses that wait for the queue to settle.
// Every accepted item runs through an in-bench model of the sorted queue
// (equal-time FIFO order, multi-hit remove, pop with periodic reinsert,
// full-queue drop). A monitor compares each done strobe field by field.
// ----------------------------------------------------------------------------
module tb_deadline_ordered_timer_queue_top;
	import dotq_pkg::*;

	localparam int QDEPTH = 16;
	localparam int N_ITEMS = 1200;
	localparam int IDLE_PCT = 16;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 8;
	localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

	typedef struct {
		logic [FUNC_W-1:0] func;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] due;
		logic              rep;
		logic [PER_W-1:0]  per;
		logic              dly;
		logic [TIME_W-1:0] now;
		bit                drain_first;
	} timer_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     fired;
		logic [ID_W-1:0]     end_id;
		logic [OCC_W-1:0]    occ;
	} timer_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [FUNC_W-1:0]   func = '0;
	logic [ID_W-1:0]     msg_id = '0;
	logic [TIME_W-1:0]   due_time = '0;
	logic                repeat_req = 1'b0;
	logic [PER_W-1:0]    period_ms = '0;
	logic                delayed = 1'b0;
	logic [TIME_W-1:0]   now_time = '0;
	logic                busy;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     fired_id;
	logic [ID_W-1:0]     end_id;
	logic [OCC_W-1:0]    occupancy;

	deadline_ordered_timer_queue_top #(.QUEUE_DEPTH(QDEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.func(func),
		.msg_id(msg_id),
		.due_time(due_time),
		.repeat_req(repeat_req),
		.period_ms(period_ms),
		.delayed(delayed),
		.now_time(now_time),
		.busy(busy),
		.done(done),
		.status(status),
		.fired_id(fired_id),
		.end_id(end_id),
		.occupancy(occupancy)
	);

	timer_cmd_t    cmd_backlog[$];
	timer_result_t due_results[$];
	timer_cmd_t    cur_cmd;
	entry_t        slot[QDEPTH];
	int            slot_count = 0;
	int            n_accepted = 0;
	int            n_done = 0;
	int            n_errors = 0;
	int            stall_cycles = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic void place_sorted(logic [TIME_W-1:0] t, logic [ID_W-1:0] id,
			logic [PER_W-1:0] per, logic rep, logic dly);
		int pos;
		int k;
		pos = 0;
		while (pos < slot_count && slot[pos].due <= t)
			pos++;
		for (k = slot_count; k > pos; k--)
			slot[k] = slot[k-1];
		slot[pos] = {t, id, per, rep, dly};
		slot_count++;
	endfunction

	function automatic timer_result_t predict_timer_result(timer_cmd_t c);
		timer_result_t res;
		entry_t head;
		int idx;
		int w;
		res = '0;
		case (c.func)
			FUNC_INSERT: begin
				if (slot_count >= QDEPTH)
					res.status = STATUS_FULL;
				else
					place_sorted(c.due, c.id, c.per, c.rep, c.dly);
			end
			FUNC_REMOVE: begin
				w = 0;
				for (idx = 0; idx < slot_count; idx++) begin
					if (slot[idx].id != c.id) begin
						slot[w] = slot[idx];
						w++;
					end
				end
				slot_count = w;
			end
			FUNC_TICK: begin
				if (slot_count > 0 && slot[0].due <= c.now) begin
					head = slot[0];
					for (idx = 1; idx < slot_count; idx++)
						slot[idx-1] = slot[idx];
					slot_count--;
					if (head.rep && head.per != '0)
						place_sorted(c.now + TIME_W'(head.per), head.id, head.per,
							head.rep, head.dly);
					res.status = STATUS_FIRED;
					res.fired = head.id;
					res.end_id = head.dly ? head.id : '0;
				end
			end
			default: begin
			end
		endcase
		res.occ = OCC_W'(slot_count);
		return res;
	endfunction

	function automatic timer_cmd_t cmd_of(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
			logic [TIME_W-1:0] due, logic rep, logic [PER_W-1:0] per, logic dly,
			logic [TIME_W-1:0] now);
		timer_cmd_t c;
		c.func = f;
		c.id = id;
		c.due = due;
		c.rep = rep;
		c.per = per;
		c.dly = dly;
		c.now = now;
		c.drain_first = 0;
		return c;
	endfunction

	function automatic void queue_cmd(timer_cmd_t c);
		cmd_backlog.insert(cmd_backlog.size(), c);
	endfunction

	function automatic timer_cmd_t noise_cmd();
		return cmd_of(FUNC_W'($urandom_range(0, 2**FUNC_W - 1)), ID_W'($urandom), $urandom,
			1'($urandom), PER_W'($urandom), 1'($urandom), $urandom);
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			n_errors++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	// driver
	always @(posedge clk) begin : drive_proc
		bit took;
		bit pending;
		bit quiet;
		took = arst_n && start && !busy;
		if (took) begin
			due_results.insert(due_results.size(), predict_timer_result(cur_cmd));
			n_accepted <= n_accepted + 1;
		end
		if (arst_n && (!start || took)) begin
			pending = (n_accepted + int'(took)) != n_done;
			quiet = (n_accepted >= 500 && n_accepted < 800);
			if (cmd_backlog.size() != 0 && !(cmd_backlog[0].drain_first && pending)
					&& (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
				cur_cmd = cmd_backlog[0];
				cmd_backlog.delete(0);
				start <= 1'b1;
				func <= cur_cmd.func;
				msg_id <= cur_cmd.id;
				due_time <= cur_cmd.due;
				repeat_req <= cur_cmd.rep;
				period_ms <= cur_cmd.per;
				delayed <= cur_cmd.dly;
				now_time <= cur_cmd.now;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin : monitor_proc
		timer_result_t want;
		if (arst_n && done) begin
			n_done <= n_done + 1;
			if (due_results.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected result expected none actual status %0h id %0h",
					$time, status, fired_id);
			end else begin
				want = due_results[0];
				due_results.delete(0);
				check_field("status", 32'(want.status), 32'(status));
				check_field("fired_id", 32'(want.fired), 32'(fired_id));
				check_field("end_id", 32'(want.end_id), 32'(end_id));
				check_field("occupancy", 32'(want.occ), 32'(occupancy));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		timer_cmd_t c;
		logic [TIME_W-1:0] t_base;
		int n;
		int k;
		int roll;

		queue_cmd(cmd_of(FUNC_TICK, 0, 0, 0, 0, 0, 0));
		queue_cmd(cmd_of(FUNC_REMOVE, 5, 0, 0, 0, 0, 0));
		queue_cmd(cmd_of(FUNC_NOP, '1, '1, 1'b1, '1, 1'b1, '1));
		queue_cmd(cmd_of(FUNC_INSERT, '1, '1, 1'b1, '1, 1'b1, 0));
		queue_cmd(cmd_of(FUNC_INSERT, 0, 0, 0, 0, 0, 0));
		queue_cmd(cmd_of(FUNC_INSERT, 7, 100, 0, 0, 1, 0));
		queue_cmd(cmd_of(FUNC_INSERT, 8, 100, 0, 0, 0, 0));
		queue_cmd(cmd_of(FUNC_INSERT, 7, 50, 1, 0, 0, 0));
		queue_cmd(cmd_of(FUNC_TICK, 0, 0, 0, 0, 0, 99));
		queue_cmd(cmd_of(FUNC_TICK, 0, 0, 0, 0, 0, 49));
		queue_cmd(cmd_of(FUNC_TICK, 0, 0, 0, 0, 0, 50));
		queue_cmd(cmd_of(FUNC_TICK, 0, 0, 0, 0, 0, 100));
		queue_cmd(cmd_of(FUNC_TICK, 0, 0, 0, 0, 0, 100));
		queue_cmd(cmd_of(FUNC_TICK, 0, 0, 0, 0, 0, 100));
		queue_cmd(cmd_of(FUNC_INSERT, 9, 10, 1, 25, 1, 0));
		queue_cmd(cmd_of(FUNC_TICK, 0, 0, 0, 0, 0, 20));
		queue_cmd(cmd_of(FUNC_TICK, 0, 0, 0, 0, 0, 45));
		c = cmd_of(FUNC_REMOVE, 9, 0, 0, 0, 0, 0);
		c.drain_first = 1;
		queue_cmd(c);
		queue_cmd(cmd_of(FUNC_INSERT, 3, 32'hFFFF_FFF0, 1, 24'h20, 0, 0));
		queue_cmd(cmd_of(FUNC_TICK, 0, 0, 0, 0, 0, 32'hFFFF_FFF8));
		queue_cmd(cmd_of(FUNC_TICK, 0, 0, 0, 0, 0, 32'h10));
		queue_cmd(cmd_of(FUNC_REMOVE, '1, 0, 0, 0, 0, 0));
		queue_cmd(cmd_of(FUNC_REMOVE, 3, 0, 0, 0, 0, 0));

		t_base = 1000;
		n = 0;
		while (n < N_ITEMS) begin
			if (n % 150 == 75) begin
				// fill past capacity with a small id pool, then clear one id
				for (k = 0; k < 18; k++) begin
					c = noise_cmd();
					c.func = FUNC_INSERT;
					c.id = ID_W'($urandom_range(1, 4));
					c.due = t_base + $urandom_range(0, 300);
					c.per = PER_W'($urandom_range(0, 100));
					queue_cmd(c);
				end
				c = noise_cmd();
				c.func = FUNC_REMOVE;
				c.id = ID_W'($urandom_range(1, 4));
				c.drain_first = 1;
				queue_cmd(c);
				n += 19;
			end else begin
				c = noise_cmd();
				roll = $urandom_range(0, 99);
				if (roll < 40) begin
					c.func = FUNC_INSERT;
					c.id = ID_W'($urandom_range(0, 15));
					c.due = t_base + $urandom_range(0, 400);
					case ($urandom_range(0, 3))
						0: c.per = '0;
						1: c.per = PER_W'($urandom);
						default: c.per = PER_W'($urandom_range(1, 200));
					endcase
				end else if (roll < 80) begin
					c.func = FUNC_TICK;
					t_base += $urandom_range(0, 60);
					c.now = ($urandom_range(0, 19) == 0) ? $urandom : t_base;
				end else if (roll < 94) begin
					c.func = FUNC_REMOVE;
					c.id = ID_W'($urandom_range(0, 15));
				end else if (roll < 97) begin
					c.func = FUNC_NOP;
				end else begin
					c.func = FUNC_INSERT;
					c.id = ID_W'($urandom_range(0, 15));
				end
				c.drain_first = (n % 100 == 50);
				queue_cmd(c);
				n++;
			end
		end

		@(posedge clk);
		while (cmd_backlog.size() != 0 || start || n_accepted != n_done)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_errors == 0 && due_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== deadline_ordered_timer_queue_top.f =====
+incdir+sv
sv/dotq_pkg.sv
sv/dotq_dp.sv
sv/dotq_ctrl.sv
sv/deadline_ordered_timer_queue_top.sv
sv/dotq_checker.sv
tb/tb_deadline_ordered_timer_queue_top.sv
